// File: rtl/gva_pkg.sv
package gva_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 25;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << FRAC_BITS;
    localparam int MAG_W      = DATA_W + 1;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ROOT_W     = 34;
    localparam int SQ_REM_W   = ROOT_W + 3;
    localparam int D3_W       = 3 * ROOT_W;
    localparam int NUM_W      = GAIN_W + MAG_W + 2 * FRAC_BITS;
    localparam int QB         = 34;
    localparam int DREM_W     = D3_W + 1;
    localparam int CNT_W      = 6;
    localparam int IN_DATA_W  = 6 * DATA_W;
    localparam int OUT_DATA_W = 4 * DATA_W;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_DIFF, OP_SQX, OP_SQY, OP_SUM, OP_ROOT, OP_RR,
        OP_D3L, OP_D3H, OP_D3S, OP_NUM, OP_DIVI, OP_DIV, OP_ACC, OP_EMIT
    } gva_op_t;

    typedef struct packed {
        gva_op_t op;
        logic    axis;
        logic    first;
    } gva_cmd_t;

    typedef struct packed {
        logic dist_zero;
    } gva_sts_t;

endpackage

// File: rtl/gravity_velocity_accumulator_unit.sv
// channel   direction  tdata fields (low bit up)                       tuser       tlast
// s_axis    in         body_x body_y body_vx body_vy star_x star_y    first_star  last_star
// m_axis    out        new_vx new_vy new_px new_py                    overflow    -
// cfg_wr    in         gravity_gain (25 bits)                         -           -
// A star is accepted only in the idle state; its processing time is set by the shared
// bit-serial square root and the restoring divider, which runs once per axis.
// A star at zero distance skips the root and the division. A last star adds an emit step.
// The result register lets the next item enter while a result waits; the emit
// step stalls only when a previous result is still untaken. Reset gives gain 1.0.
module gravity_velocity_accumulator_unit
    import gva_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // body_x, body_y, body_vx, body_vy, star_x, star_y
    input  logic                  s_axis_tuser,   // first_star
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // new_vx, new_vy, new_px, new_py
    output logic                  m_axis_tuser,   // overflow
    input  logic                  cfg_wr_en,
    input  logic [GAIN_W-1:0]     cfg_wr_data
);

    gva_cmd_t cmd;
    gva_sts_t sts;

    gva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_first  (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    gva_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_axis_tdata),
        .out_data    (m_axis_tdata),
        .out_flag    (m_axis_tuser)
    );

endmodule

// File: rtl/gva_datapath.sv
module gva_datapath
    import gva_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  gva_cmd_t              cmd,
    output gva_sts_t              sts,
    input  logic                  cfg_wr_en,
    input  logic [GAIN_W-1:0]     cfg_wr_data,
    input  logic [IN_DATA_W-1:0]  in_data,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_flag
);

    logic [GAIN_W-1:0]   gain_reg;
    logic [DATA_W-1:0]   held_px_reg, held_py_reg, acc_vx_reg, acc_vy_reg;
    logic                sat_reg;
    logic [DATA_W-1:0]   star_x_reg, star_y_reg;
    logic [MAG_W-1:0]    mx_reg, my_reg;
    logic                negx_reg, negy_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   sq_op_reg;
    logic [SQ_REM_W-1:0] sq_rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [MUL_W-1:0]    rr_hi_reg;
    logic [D3_W-1:0]     d3_reg;
    logic [DREM_W-1:0]   drem_reg;
    logic [QB-1:0]       nlo_reg;
    logic [QB-1:0]       q_reg;
    logic                big_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                out_flag_reg;

    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [MAG_W-1:0]    dx, dy, mx, my;
    logic [SQ_REM_W-1:0] sq_t, sq_trial;
    logic [NUM_W-1:0]    num;
    logic [DREM_W-1:0]   drem_init, drem_t, den;
    logic [MAG_W-1:0]    q33, tneg;
    logic                neg_sel, term_sat;
    logic [DATA_W-1:0]   term, acc_sel, acc_new;
    logic [MAG_W-1:0]    vsum, pxs, pys;
    logic                vsat, pxsat, pysat;
    logic [DATA_W:0]     pxc, pyc;

    function automatic logic [DATA_W:0] clamp33(input logic [MAG_W-1:0] v);
        logic [DATA_W:0] r;
        if (v[DATA_W] != v[DATA_W-1])
            r = {1'b1, v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}}};
        else
            r = {1'b0, v[DATA_W-1:0]};
        return r;
    endfunction

    assign sts.dist_zero = (mx_reg == '0) && (my_reg == '0);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SQX:  begin mul_a = MUL_W'(mx_reg); mul_b = MUL_W'(mx_reg); end
            OP_SQY:  begin mul_a = MUL_W'(my_reg); mul_b = MUL_W'(my_reg); end
            OP_RR:   begin mul_a = root_reg; mul_b = root_reg; end
            OP_D3L:  begin mul_a = prod_reg[MUL_W-1:0]; mul_b = root_reg; end
            OP_D3H:  begin mul_a = rr_hi_reg; mul_b = root_reg; end
            OP_NUM:
            begin
                mul_a = MUL_W'(gain_reg);
                mul_b = MUL_W'(cmd.axis ? my_reg : mx_reg);
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        dx = {star_x_reg[DATA_W-1], star_x_reg} - {held_px_reg[DATA_W-1], held_px_reg};
        dy = {star_y_reg[DATA_W-1], star_y_reg} - {held_py_reg[DATA_W-1], held_py_reg};
        mx = dx[DATA_W] ? (MAG_W'(0) - dx) : dx;
        my = dy[DATA_W] ? (MAG_W'(0) - dy) : dy;

        sq_t     = {sq_rem_reg[SQ_REM_W-3:0], sq_op_reg[PROD_W-1:PROD_W-2]};
        sq_trial = SQ_REM_W'({root_reg, 2'b01});

        num       = NUM_W'(prod_reg) << (2 * FRAC_BITS);
        drem_init = DREM_W'(num >> QB);
        den       = DREM_W'(d3_reg);
        drem_t    = {drem_reg[DREM_W-2:0], nlo_reg[QB-1]};

        // cap the quotient at 2^32, already out of range
        if (big_reg || q_reg[QB-1] || (q_reg[DATA_W] && (q_reg[DATA_W-1:0] != '0)))
            q33 = {1'b1, {DATA_W{1'b0}}};
        else
            q33 = q_reg[MAG_W-1:0];
        tneg    = MAG_W'(0) - q33;
        neg_sel = cmd.axis ? negy_reg : negx_reg;
        if (neg_sel)
        begin
            term_sat = q33 > {2'b01, {(DATA_W-1){1'b0}}};
            term     = term_sat ? {1'b1, {(DATA_W-1){1'b0}}} : tneg[DATA_W-1:0];
        end
        else
        begin
            term_sat = q33[DATA_W] | q33[DATA_W-1];
            term     = term_sat ? {1'b0, {(DATA_W-1){1'b1}}} : q33[DATA_W-1:0];
        end
        acc_sel = cmd.axis ? acc_vy_reg : acc_vx_reg;
        vsum    = {acc_sel[DATA_W-1], acc_sel} + {term[DATA_W-1], term};
        {vsat, acc_new} = clamp33(vsum);

        pxs = {held_px_reg[DATA_W-1], held_px_reg} + {acc_vx_reg[DATA_W-1], acc_vx_reg};
        pys = {held_py_reg[DATA_W-1], held_py_reg} + {acc_vy_reg[DATA_W-1], acc_vy_reg};
        pxsat = pxs[DATA_W] != pxs[DATA_W-1];
        pysat = pys[DATA_W] != pys[DATA_W-1];
        pxc   = clamp33(pxs);
        pyc   = clamp33(pys);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= GAIN_RESET;
            held_px_reg <= '0;
            held_py_reg <= '0;
            acc_vx_reg  <= '0;
            acc_vy_reg  <= '0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                gain_reg <= cfg_wr_data;
            if (cmd.op == OP_LOAD && cmd.first)
            begin
                held_px_reg <= in_data[DATA_W-1:0];
                held_py_reg <= in_data[2*DATA_W-1:DATA_W];
                acc_vx_reg  <= in_data[3*DATA_W-1:2*DATA_W];
                acc_vy_reg  <= in_data[4*DATA_W-1:3*DATA_W];
                sat_reg     <= 1'b0;
            end
            if (cmd.op == OP_ACC)
            begin
                if (cmd.axis)
                    acc_vy_reg <= acc_new;
                else
                    acc_vx_reg <= acc_new;
                sat_reg <= sat_reg | vsat | term_sat;
            end
            if (cmd.op == OP_EMIT)
                sat_reg <= sat_reg | pxsat | pysat;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_NOP: ;
            OP_LOAD:
            begin
                star_x_reg <= in_data[5*DATA_W-1:4*DATA_W];
                star_y_reg <= in_data[6*DATA_W-1:5*DATA_W];
            end
            OP_DIFF:
            begin
                mx_reg   <= mx;
                my_reg   <= my;
                negx_reg <= dx[DATA_W];
                negy_reg <= dy[DATA_W];
            end
            OP_SQX: prod_reg <= mul_p;
            OP_SQY:
            begin
                sq_op_reg <= prod_reg;
                prod_reg  <= mul_p;
            end
            OP_SUM:
            begin
                sq_op_reg  <= sq_op_reg + prod_reg;
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            OP_ROOT:
            begin
                sq_op_reg <= sq_op_reg << 2;
                if (sq_t >= sq_trial)
                begin
                    sq_rem_reg <= sq_t - sq_trial;
                    root_reg   <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg <= sq_t;
                    root_reg   <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            OP_RR: prod_reg <= mul_p;
            OP_D3L:
            begin
                rr_hi_reg <= prod_reg[PROD_W-1:MUL_W];
                prod_reg  <= mul_p;
            end
            OP_D3H:
            begin
                d3_reg   <= D3_W'(prod_reg);
                prod_reg <= mul_p;
            end
            OP_D3S: d3_reg <= d3_reg + (D3_W'(prod_reg) << MUL_W);
            OP_NUM: prod_reg <= mul_p;
            OP_DIVI:
            begin
                drem_reg <= drem_init;
                big_reg  <= drem_init >= den;
                nlo_reg  <= num[QB-1:0];
                q_reg    <= '0;
            end
            OP_DIV:
            begin
                nlo_reg <= nlo_reg << 1;
                if (drem_t >= den)
                begin
                    drem_reg <= drem_t - den;
                    q_reg    <= {q_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_t;
                    q_reg    <= {q_reg[QB-2:0], 1'b0};
                end
            end
            OP_ACC: ;
            OP_EMIT:
            begin
                out_data_reg <= {pyc[DATA_W-1:0], pxc[DATA_W-1:0], acc_vy_reg, acc_vx_reg};
                out_flag_reg <= sat_reg | pxsat | pysat;
            end
        endcase
    end

    assign out_data = out_data_reg;
    assign out_flag = out_flag_reg;

endmodule

// File: rtl/gva_ctrl.sv
module gva_ctrl
    import gva_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     in_first,
    input  logic     in_last,
    output logic     out_valid,
    input  logic     out_ready,
    output gva_cmd_t cmd,
    input  gva_sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_SQX, S_SQY, S_SUM, S_ROOT, S_RR, S_D3L, S_D3H, S_D3S,
        S_NUM, S_DIVI, S_DIV, S_ACC, S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             axis_reg, axis_next;
    logic             last_reg, last_next;
    logic             valid_reg, valid_next;
    logic             out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;
    assign out_free  = !valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !out_ready;
        cmd.op     = OP_NOP;
        cmd.axis   = axis_reg;
        cmd.first  = in_first;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    last_next  = in_last;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                // skip a star at zero distance
                if (sts.dist_zero)
                    state_next = last_reg ? S_EMIT : S_IDLE;
                else
                begin
                    cmd.op     = OP_SQX;
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                cmd.op     = OP_SQY;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.op     = OP_SUM;
                cnt_next   = CNT_W'(ROOT_W - 1);
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.op   = OP_ROOT;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_RR;
            end
            S_RR:
            begin
                cmd.op     = OP_RR;
                state_next = S_D3L;
            end
            S_D3L:
            begin
                cmd.op     = OP_D3L;
                state_next = S_D3H;
            end
            S_D3H:
            begin
                cmd.op     = OP_D3H;
                state_next = S_D3S;
            end
            S_D3S:
            begin
                cmd.op     = OP_D3S;
                axis_next  = 1'b0;
                state_next = S_NUM;
            end
            S_NUM:
            begin
                cmd.op     = OP_NUM;
                state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.op     = OP_DIVI;
                cnt_next   = CNT_W'(QB - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = S_NUM;
                end
                else
                    state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.op     = OP_EMIT;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= 1'b0;
            last_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
            last_reg  <= last_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// File: tb/gravity_velocity_accumulator_unit_tb.sv
module gravity_velocity_accumulator_unit_tb;
    import gva_pkg::*;

    typedef struct {
        logic signed [31:0] bx, by, bvx, bvy, sx, sy;
        logic               first, last;
    } star_item_t;

    typedef struct {
        logic signed [31:0] vx, vy, px, py;
        logic               ovf;
    } body_state_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int DRAIN_CYCLES   = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_wr_en;
    logic [GAIN_W-1:0]     cfg_wr_data;

    star_item_t  star_queue[$];
    body_state_t expected_bodies[$];
    int          error_count;
    int          idle_cycles;
    int          send_gap;
    int          recv_gap;
    int          hold_cnt;
    bit          hold_start;
    bit          hold_done;
    bit          busy_mode;

    // predictor state
    logic [GAIN_W-1:0]  gain_m;
    logic signed [31:0] vel_x, vel_y, pos_x, pos_y;
    bit                 sat_flag;

    gravity_velocity_accumulator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
        begin
            sat_flag = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            sat_flag = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic longint pull(longint d, logic [101:0] dist3);
        logic [127:0] num;
        logic [127:0] q;
        longint       mag;
        mag = (d < 0) ? -d : d;
        num = (128'(gain_m) * 128'(mag)) << (2 * FRAC_BITS);
        q = num / 128'(dist3);
        // cap just outside the 32-bit range; clamp decides the rest
        if (q > 128'h1_0000_0000)
            q = 128'h1_0000_0000;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void add_pull(logic signed [31:0] sx, logic signed [31:0] sy);
        longint       dx, dy;
        logic [32:0]  mx, my;
        logic [65:0]  r2;
        logic [33:0]  root, c;
        logic [101:0] d3;
        dx = longint'(sx) - longint'(pos_x);
        dy = longint'(sy) - longint'(pos_y);
        mx = (dx < 0) ? 33'(-dx) : 33'(dx);
        my = (dy < 0) ? 33'(-dy) : 33'(dy);
        if (mx == 0 && my == 0)
            return;
        r2 = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
        root = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = root | (34'd1 << b);
            if (68'(c) * 68'(c) <= 68'(r2))
                root = c;
        end
        d3 = 102'(root) * 102'(root) * 102'(root);
        vel_x = sat32(longint'(vel_x) + longint'(sat32(pull(dx, d3))));
        vel_y = sat32(longint'(vel_y) + longint'(sat32(pull(dy, d3))));
    endfunction

    function automatic void predict_star(star_item_t it);
        body_state_t r;
        if (it.first)
        begin
            pos_x = it.bx;
            pos_y = it.by;
            vel_x = it.bvx;
            vel_y = it.bvy;
            sat_flag = 1'b0;
        end
        add_pull(it.sx, it.sy);
        if (it.last)
        begin
            r.px = sat32(longint'(pos_x) + longint'(vel_x));
            r.py = sat32(longint'(pos_y) + longint'(vel_y));
            r.vx = vel_x;
            r.vy = vel_y;
            r.ovf = sat_flag;
            expected_bodies = {expected_bodies, r};
        end
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", field, got, want);
        error_count++;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] near(logic signed [31:0] v);
        case ($urandom_range(0, 4))
            0: return v;
            1: return v + $signed($urandom_range(0, 64)) - 32;
            2: return $urandom();
            default: return v + $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic void push_star(logic signed [31:0] bx, by, bvx, bvy, sx, sy,
                                      logic first, logic last);
        star_item_t it;
        it.bx = bx; it.by = by; it.bvx = bvx; it.bvy = bvy;
        it.sx = sx; it.sy = sy; it.first = first; it.last = last;
        star_queue = {star_queue, it};
    endfunction

    function automatic void push_random_bodies(int n_items);
        logic signed [31:0] bx, by;
        int                 n;
        int                 count;
        count = 0;
        while (count < n_items)
        begin
            bx = pick_value();
            by = pick_value();
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                // mostly well-formed bodies, some noise on the frame flags
                if ($urandom_range(0, 9) == 0)
                    push_star($urandom(), $urandom(), $urandom(), $urandom(),
                              near(bx), near(by), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                else
                    push_star(i == 0 ? bx : $urandom(), i == 0 ? by : $urandom(),
                              pick_value(), pick_value(), near(bx), near(by),
                              i == 0, i == n - 1);
                count++;
            end
        end
    endfunction

    task automatic wait_drained();
        while (star_queue.size() != 0 || s_axis_tvalid || expected_bodies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gain(logic [GAIN_W-1:0] g);
        cfg_wr_data <= g;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        gain_m = g;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        star_item_t it;
        logic       nv;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            s_axis_tlast  <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                nv = 1'b0;
                send_gap = busy_mode ? 0 : $urandom_range(0, 16);
            end
            if (!nv)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (star_queue.size() != 0)
                begin
                    it = star_queue.pop_front();
                    predict_star(it);
                    s_axis_tdata <= {it.sy, it.sx, it.bvy, it.bvx, it.by, it.bx};
                    s_axis_tuser <= it.first;
                    s_axis_tlast <= it.last;
                    nv = 1'b1;
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        body_state_t want;
        logic        nr;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
            hold_cnt = 0;
        end
        else
        begin
            nr = m_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bodies.size() == 0)
                begin
                    $display("unexpected result %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_bodies.pop_front();
                    if (m_axis_tdata[31:0] !== want.vx)
                        report_mismatch("new_vx", m_axis_tdata[31:0], want.vx);
                    if (m_axis_tdata[63:32] !== want.vy)
                        report_mismatch("new_vy", m_axis_tdata[63:32], want.vy);
                    if (m_axis_tdata[95:64] !== want.px)
                        report_mismatch("new_px", m_axis_tdata[95:64], want.px);
                    if (m_axis_tdata[127:96] !== want.py)
                        report_mismatch("new_py", m_axis_tdata[127:96], want.py);
                    if (m_axis_tuser !== want.ovf)
                        report_mismatch("overflow", m_axis_tuser, want.ovf);
                end
                nr = 1'b0;
                recv_gap = busy_mode ? 0 : $urandom_range(0, 16);
            end
            if (hold_start && !hold_done)
            begin
                hold_cnt = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                nr = 1'b0;
            end
            else if (!nr)
            begin
                if (recv_gap > 0)
                    recv_gap--;
                else
                    nr = 1'b1;
            end
            m_axis_tready <= nr;
        end
    end

    // watchdog: stop if nothing moves while work is pending
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (star_queue.size() == 0 && !s_axis_tvalid && expected_bodies.size() == 0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [GAIN_W-1:0] gains[4];
        error_count = 0;
        idle_cycles = 0;
        hold_start = 1'b0;
        hold_done = 1'b0;
        busy_mode = 1'b0;
        gain_m = GAIN_RESET;
        vel_x = '0; vel_y = '0; pos_x = '0; pos_y = '0;
        sat_flag = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // stars before any first item accumulate onto the reset state
        push_star(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sh0001_0000, 32'sh0002_0000, 1'b0, 1'b0);
        push_star(32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sh0003_0000, 32'sd5, 1'b0, 1'b1);
        // zero distance, first and last together
        push_star(32'sh0010_0000, -32'sh0010_0000, 32'sh0000_8000, 32'sd1,
                  32'sh0010_0000, -32'sh0010_0000, 1'b1, 1'b1);
        // one LSB away: term saturates
        push_star(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 1'b1, 1'b1);
        push_star(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1, 1'b1, 1'b1);
        // widest distance
        push_star(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                  32'sh80000000, 32'sh80000000, 1'b1, 1'b1);
        push_star(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh80000000, 1'b1, 1'b1);
        // velocity sum and position sum saturation
        push_star(32'sh7fff0000, 32'sh80010000, 32'sh7ffffff0, 32'sh80000010,
                  32'sh7fff0100, 32'sh80010000, 1'b1, 1'b1);
        push_star(32'sh7fffffff, 32'sh80000000, 32'sh0001_0000, -32'sh0001_0000,
                  32'sh0000_0000, 32'sh0000_0000, 1'b1, 1'b1);
        // multi-star body including a zero-distance star in the middle
        push_star(32'sh0005_0000, 32'sh0005_0000, -32'sh0000_4000, 32'sh0000_4000,
                  32'sh0006_0000, 32'sh0005_0000, 1'b1, 1'b0);
        push_star(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sh0005_0000, 32'sh0005_0000, 1'b0, 1'b0);
        push_star(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sh0004_0000, 32'sh0003_0000, 1'b0, 1'b1);
        push_star($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  1'b0, 1'b1);
        wait_drained();

        gains[0] = '0;
        gains[1] = 25'd16777216;
        gains[2] = {GAIN_W{1'b1}};
        gains[3] = GAIN_W'($urandom_range(1, 25'h0ff_ffff));
        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
                write_gain(gains[p - 1]);
            busy_mode = (p == 2);
            push_random_bodies(380);
            if (p == 1)
                hold_start = 1'b1;
            wait_drained();
        end

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
